FILE: design/aes_ctr_pkg.sv
package aes_ctr_pkg;

  localparam int unsigned KeyBytesDefault = 24;
  localparam logic [63:0] VerifyAdd = 64'h0000_0000_0012_3456;
  localparam logic [7:0] MagicByte = 8'h3C;
  localparam logic [47:0] CtrOne = 48'd1;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_VERIFY = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_MID  = 2'd1,
    REG_KEY_HIGH = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  // Control tag carried down the cell chain alongside the state.
  typedef struct packed {
    logic valid;
    logic verify;
  } tag_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input int unsigned n);
    logic [7:0] rc;
    rc = 8'h01;
    for (int unsigned k = 0; k < 16; k++) begin
      if (k < n) rc = xtime(rc);
    end
    return rc;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte-ordered state: byte i in bits 8i+7:8i.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = sbox(s[8*(4*((c+i)%4)+i) +: 8]);
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[8*i +: 8] = t[i] ^ rk[8*i +: 8];
    return o;
  endfunction

endpackage

FILE: design/aes_ctr_cell.sv
// One chain cell: a round of the block and the matching key-expansion words.
// Keys ride along with the data, so each item sees the key it entered with.
module aes_ctr_cell import aes_ctr_pkg::*; #(
  parameter int unsigned Nk = 6,
  parameter int unsigned Round = 1,
  parameter int unsigned Nr = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  tag_t                tag_i,
  input  logic [127:0]        state_i,
  input  logic [127:0]        pad_i,
  input  logic [32*Nk-1:0]    win_i,  // last Nk expanded words so far
  output tag_t                tag_o,
  output logic [127:0]        state_o,
  output logic [127:0]        pad_o,
  output logic [32*Nk-1:0]    win_o
);

  // Index of the first word this cell expands; the window holds words
  // Base-Nk .. Base-1.
  localparam int unsigned Base = Nk + 4 * (Round - 1);

  logic [32*Nk-1:0] win_d;
  logic [127:0]     rk;
  logic [31:0]      tmp;
  logic [31:0]      wi;

  // Expand four words beyond the window end; round key = words 4R..4R+3.
  always_comb begin
    logic [32*(Nk+4)-1:0] ext;
    ext = {128'b0, win_i};
    for (int k = 0; k < 4; k++) begin
      tmp = ext[32*(Nk-1+k) +: 32];
      if (((Base + k) % Nk) == 0) begin
        tmp = sub_word({tmp[7:0], tmp[31:8]}) ^
              {24'b0, rcon((Base + k) / Nk - 1)};
      end else if (Nk > 6 && ((Base + k) % Nk) == 4) begin
        tmp = sub_word(tmp);
      end
      wi = ext[32*k +: 32] ^ tmp;
      ext[32*(Nk+k) +: 32] = wi;
    end
    // Position j holds word 4R-4+j, so the round key sits at positions 4..7.
    rk = ext[32*4 +: 128];
    win_d = ext[32*4 +: 32*Nk];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_o <= '0;
    end else if (en_i) begin
      tag_o <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_o <= aes_round(state_i, rk, Round == Nr);
      pad_o   <= pad_i;
      win_o   <= win_d;
    end
  end

endmodule

FILE: design/aes192_ctr_stream_decryptor_top.sv
// A data or verify item is loaded into the entry register at the edge that
// accepts it, then passes through each of the Nr round cells in turn.
// Throughput: one item per cycle; the chain of round cells advances as a
// whole, so it moves whenever the output stage is empty or being taken.
// Reset: rst_ni clears key, counter and all valid flags asynchronously.
module aes192_ctr_stream_decryptor_top import aes_ctr_pkg::*; #(
  parameter int unsigned KEY_BYTES = KeyBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] text_low_o,
  output logic [63:0] text_high_o,
  output logic        magic_ok_o
);

  // Key words clamped to 4..8, rounds = words + 6.
  localparam int unsigned NkRaw = KEY_BYTES / 4;
  localparam int unsigned Nk = (NkRaw < 4) ? 4 : ((NkRaw > 8) ? 8 : NkRaw);
  localparam int unsigned Nr = Nk + 6;

  logic [63:0] key_low_q, key_mid_q, key_high_q;
  logic [63:0] ctr_lo_q, ctr_hi_q;
  logic        adv;
  logic        accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_mid_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_MID:  key_mid_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Chain of cells, stage 0 is the entry register (whitened block).
  tag_t            tag   [Nr+1];
  logic [127:0]    st    [Nr+1];
  logic [127:0]    pad   [Nr+1];
  logic [32*Nk-1:0] win  [Nr+1];

  assign adv        = !(tag[Nr].valid && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // Counter source for this item.
  logic [127:0] ctr_blk;
  logic [64:0]  vsum;
  logic [191:0] key_all;
  logic [255:0] key_pad;
  logic [32*Nk-1:0] key_words;
  logic         kind_out;

  always_comb begin
    vsum    = {1'b0, ctr_lo_q} + {1'b0, VerifyAdd};
    ctr_blk = {ctr_hi_q, ctr_lo_q};
    if (kind_e'(kind_i) == KIND_VERIFY) begin
      ctr_blk = {ctr_hi_q + {63'b0, vsum[64]}, vsum[63:0]};
    end
    key_all   = {key_high_q, key_mid_q, key_low_q};
    key_pad   = {64'b0, key_all};
    key_words = key_pad[32*Nk-1:0];
    kind_out  = (kind_e'(kind_i) == KIND_DATA) || (kind_e'(kind_i) == KIND_VERIFY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_lo_q <= '0;
      ctr_hi_q <= '0;
      tag[0]   <= '0;
    end else if (accept || adv) begin
      // bubbles carry neither flag, so the magic flag never shows without a result
      tag[0] <= '{valid: accept && kind_out,
                  verify: accept && (kind_e'(kind_i) == KIND_VERIFY)};
      if (accept) begin
        case (kind_e'(kind_i))
          KIND_LOAD: begin
            ctr_lo_q <= block_low_i;
            ctr_hi_q <= block_high_i;
          end
          KIND_DATA: ctr_lo_q <= {ctr_lo_q[63:48], ctr_lo_q[47:0] + CtrOne};
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st[0]   <= ctr_blk ^ key_words[127:0];
      pad[0]  <= {block_high_i, block_low_i};
      win[0]  <= key_words;
    end
  end

  for (genvar r = 1; r <= Nr; r++) begin : g_cell
    aes_ctr_cell #(.Nk(Nk), .Round(r), .Nr(Nr)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .tag_i   (tag[r-1]),
      .state_i (st[r-1]),
      .pad_i   (pad[r-1]),
      .win_i   (win[r-1]),
      .tag_o   (tag[r]),
      .state_o (st[r]),
      .pad_o   (pad[r]),
      .win_o   (win[r])
    );
  end

  logic [127:0] txt;
  assign txt         = st[Nr] ^ pad[Nr];
  assign out_valid_o = tag[Nr].valid;
  assign text_low_o  = txt[63:0];
  assign text_high_o = txt[127:64];
  assign magic_ok_o  = tag[Nr].verify && (txt[7:0] == MagicByte) && (txt[15:8] == MagicByte);

endmodule

FILE: design/aes_ctr_checker.sv
module aes_ctr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] text_low_o,
  input logic        magic_ok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(text_low_o))
    else $error("stalled result changed");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room");

  a_magic_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    magic_ok_o |-> out_valid_o)
    else $error("flag without result");

endmodule

bind aes192_ctr_stream_decryptor_top aes_ctr_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .text_low_o(text_low_o),
  .magic_ok_o(magic_ok_o)
);

FILE: bench/aes192_ctr_stream_decryptor_top_test.sv
`timescale 1ns / 100ps

module aes192_ctr_stream_decryptor_top_test import aes_ctr_pkg::*;;

  // Leave a wide margin over the result latency for a 24-byte key.
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  kind_i;
  logic [63:0] block_low_i;
  logic [63:0] block_high_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] text_low_o;
  logic [63:0] text_high_o;
  logic        magic_ok_o;

  aes192_ctr_stream_decryptor_top dut (.*);

  // Expected plaintext item.
  typedef struct packed {
    logic [63:0] text_low;
    logic [63:0] text_high;
    logic        magic_ok;
  } plain_t;

  plain_t plain_q[$];

  // Shadow of the key registers and the counter block.
  logic [63:0] key_sh [3];
  logic [63:0] ctr_lo;
  logic [63:0] ctr_hi;

  int unsigned mismatches;
  int unsigned cycles;
  bit          hold_stall; // keep out_stall_i low while draining

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round-key expansion and AES encryption of one 16-byte block.
  function automatic logic [127:0] block_cipher(input logic [127:0] blk);
    logic [7:0]   w [208];
    logic [7:0]   tmp [4];
    logic [7:0]   x;
    logic [7:0]   rc;
    logic [127:0] s;
    logic [127:0] rk;
    logic [191:0] key;
    int unsigned  nk;
    int unsigned  nr;
    nk  = 6;
    nr  = 12;
    rc  = 8'h01;
    key = {key_sh[2], key_sh[1], key_sh[0]};
    for (int i = 0; i < 24; i++) w[i] = key[8*i +: 8];
    for (int i = nk; i < 4*(nr+1); i++) begin
      for (int c = 0; c < 4; c++) tmp[c] = w[4*(i-1)+c];
      if (i % nk == 0) begin
        x      = tmp[0];
        tmp[0] = sbox(tmp[1]) ^ rc;
        tmp[1] = sbox(tmp[2]);
        tmp[2] = sbox(tmp[3]);
        tmp[3] = sbox(x);
        rc     = xtime(rc);
      end
      for (int c = 0; c < 4; c++) w[4*i+c] = w[4*(i-nk)+c] ^ tmp[c];
    end
    for (int i = 0; i < 16; i++) s[8*i +: 8] = blk[8*i +: 8] ^ w[i];
    for (int r = 1; r <= nr; r++) begin
      for (int i = 0; i < 16; i++) rk[8*i +: 8] = w[16*r+i];
      s = aes_round(s, rk, r == nr);
    end
    return s;
  endfunction

  // Update the shadow state for one accepted item, queue any plaintext.
  task automatic predict_plain(input logic [1:0] kind, input logic [63:0] lo,
                               input logic [63:0] hi);
    logic [127:0] ks;
    logic [64:0]  sum;
    logic [63:0]  clo;
    logic [63:0]  chi;
    plain_t       p;
    clo = ctr_lo;
    chi = ctr_hi;
    case (kind)
      KIND_LOAD: begin
        ctr_lo = lo;
        ctr_hi = hi;
      end
      KIND_DATA, KIND_VERIFY: begin
        if (kind == KIND_VERIFY) begin
          sum = {1'b0, clo} + {1'b0, VerifyAdd};
          clo = sum[63:0];
          chi = chi + sum[64];
        end
        ks          = block_cipher({chi, clo});
        p.text_low  = ks[63:0] ^ lo;
        p.text_high = ks[127:64] ^ hi;
        p.magic_ok  = 1'b0;
        if (kind == KIND_DATA) begin
          // only the low six bytes count, wrapping without carry
          ctr_lo[47:0] = ctr_lo[47:0] + CtrOne;
        end else begin
          p.magic_ok = (p.text_low[7:0] == MagicByte) && (p.text_low[15:8] == MagicByte);
        end
        plain_q.push_back(p);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Send one item; it is accepted at an edge with in_stall_o low.
  task automatic send_item(input logic [1:0] kind, input logic [63:0] lo,
                           input logic [63:0] hi, input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    block_low_i  <= lo;
    block_high_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
    predict_plain(kind, lo, hi);
  endtask

  task automatic idle_inputs();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all plaintext, then for the pipe to empty of no-result items.
  task automatic drain();
    hold_stall = 1'b1;
    while (plain_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    hold_stall = 1'b0;
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx != REG_NONE) key_sh[idx] = val;
  endtask

  task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] k2);
    write_reg(REG_KEY_LOW, k0);
    write_reg(REG_KEY_MID, k1);
    write_reg(REG_KEY_HIGH, k2);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Reset key, edges of the fields, every kind, counter wrap, magic match.
  task automatic test_directed();
    logic [127:0] ks;
    logic [63:0]  vlo;
    logic [63:0]  vhi;
    logic [64:0]  sum;
    send_item(KIND_DATA, 64'd0, 64'd0, 1'b0);
    send_item(KIND_VERIFY, '1, '1, 1'b0);
    idle_inputs();
    drain();
    set_key('1, '1, '1);
    send_item(KIND_LOAD, 64'h0000_FFFF_FFFF_FFFE, '1, 1'b0);
    send_item(KIND_DATA, '1, 64'd0, 1'b0);
    send_item(KIND_DATA, 64'd0, '1, 1'b0);
    send_item(KIND_DATA, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(KIND_NONE, '1, '1, 1'b0);
    send_item(KIND_DATA, 64'd1, 64'd2, 1'b0);
    // verify add carries from the low half into the high half
    send_item(KIND_LOAD, '1, '1, 1'b0);
    send_item(KIND_VERIFY, 64'd0, 64'd0, 1'b0);
    send_item(KIND_LOAD, 64'hFFFF_FFFF_FFF0_0000, 64'h1234, 1'b0);
    send_item(KIND_VERIFY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
    idle_inputs();
    drain();
    set_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'h1716_1514_1312_1110);
    write_reg(REG_NONE, '1);
    cfg_valid_i <= 1'b0;
    // build a verify block whose plaintext starts with two magic bytes
    send_item(KIND_LOAD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0);
    sum = {1'b0, ctr_lo} + {1'b0, VerifyAdd};
    ks  = block_cipher({ctr_hi + sum[64], sum[63:0]});
    vlo = ks[63:0] ^ 64'h1122_3344_5566_3C3C;
    vhi = ks[127:64] ^ 64'h0;
    send_item(KIND_VERIFY, vlo, vhi, 1'b0);
    // first byte matches, second does not
    send_item(KIND_VERIFY, vlo ^ 64'h0100, vhi, 1'b0);
    send_item(KIND_DATA, 64'd0, 64'd0, 1'b0);
    send_item(KIND_VERIFY, vlo, vhi, 1'b0);
    idle_inputs();
    drain();
  endtask

  // Streams of data items after a load, with verify and stray items mixed in.
  task automatic test_random(input int unsigned items);
    int unsigned n;
    int unsigned r;
    logic [63:0] lo;
    logic [63:0] hi;
    n = 0;
    while (n < items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        lo = rand64();
        if ($urandom_range(0, 3) == 0) lo[47:0] = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 3);
        send_item(KIND_LOAD, lo, rand64(), 1'b1);
      end else if (r < 80) send_item(KIND_DATA, rand64(), rand64(), 1'b1);
      else if (r < 95) send_item(KIND_VERIFY, rand64(), rand64(), 1'b1);
      else send_item(KIND_NONE, rand64(), rand64(), 1'b1);
      n++;
      // bursts with no gaps now and then
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(4, 12)) begin
          send_item(KIND_DATA, rand64(), rand64(), 1'b0);
          n++;
        end
      end
    end
    idle_inputs();
    drain();
  endtask

  task automatic test_key_sweep();
    set_key(64'd0, 64'd0, 64'd0);
    test_random(60);
    set_key(rand64(), rand64(), rand64());
    test_random(140);
    set_key(rand64(), '1, rand64());
    test_random(140);
  endtask

  // Receiver stall: random gaps, short mostly, a few long.
  initial begin
    int unsigned g;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_stall) out_stall_i <= 1'b0;
      else begin
        g = gap_len();
        if (g == 0) out_stall_i <= 1'b0;
        else begin
          out_stall_i <= 1'b1;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    plain_t got;
    plain_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{text_low: text_low_o, text_high: text_high_o, magic_ok: magic_ok_o};
      if (plain_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %h %h %b", got.text_low,
                                       got.text_high, got.magic_ok);
      end else begin
        want = plain_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %b got %h %h %b", want.text_low, want.text_high,
                     want.magic_ok, got.text_low, got.text_high, got.magic_ok);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    mismatches   = 0;
    hold_stall   = 1'b0;
    key_sh[0]    = '0;
    key_sh[1]    = '0;
    key_sh[2]    = '0;
    ctr_lo       = '0;
    ctr_hi       = '0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_KEY_LOW;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_LOAD;
    block_low_i  = '0;
    block_high_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_key_sweep();
    if (plain_q.size() != 0) mismatches++;
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
